### src/prc_pkg.sv
`timescale 1ns / 1ps

package prc_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int ANGLE_BITS_DEF = 16;
    localparam int STAGES_DEF     = 18;
    localparam int MAX_STAGES     = 32;

    // The datapath keeps (58 - COORD_BITS) fraction bits, so integer plus
    // fraction plus headroom is the same width for every coordinate size.
    localparam int FRAC_BASE   = 58;
    localparam int DATA_W      = 62;
    localparam int TURN_BITS   = 32;
    localparam int RESID_BITS  = 30;
    localparam int ZW          = 34;
    localparam int FRONT_DEPTH = 4;
    localparam int BACK_DEPTH  = 2;

    localparam logic [TURN_BITS-1:0] ATAN_TURN [MAX_STAGES] = '{
        32'h20000000, 32'h12E4051D, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2E,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001,
        32'h00000000, 32'h00000000
    };

    function automatic int stages_used(input int n);
        return (n > MAX_STAGES) ? MAX_STAGES : n;
    endfunction

    function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] r;
        logic [63:0] q;
        r = '0;
        q = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] isqrt_u64(input logic [63:0] v);
        logic [63:0] n;
        logic [63:0] r;
        logic [63:0] b;
        n = v;
        r = '0;
        b = 64'd1 << 62;
        for (int k = 0; k < 32; k++)
        begin
            if (b > n)
            begin
                b = b >> 2;
            end
        end
        for (int k = 0; k < 32; k++)
        begin
            if (b != 64'd0)
            begin
                if (n >= r + b)
                begin
                    n = n - (r + b);
                    r = (r >> 1) + b;
                end
                else
                begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        return r;
    endfunction

    // CORDIC gain in Q31: K squared is built in Q62, then its square root taken.
    function automatic logic [63:0] gain_q31(input int n);
        logic [63:0] k2;
        k2 = 64'd1 << 62;
        for (int i = 0; i < MAX_STAGES; i++)
        begin
            if (i < n)
            begin
                k2 = k2 - div_u64(k2, (64'd1 << (2 * i)) + 64'd1);
            end
        end
        return isqrt_u64(k2);
    endfunction

endpackage

### src/prc_if.sv
`timescale 1ns / 1ps

interface prc_point_if
    import prc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int ANGLE_BITS = ANGLE_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] center_x;
    logic signed [COORD_BITS-1:0] center_y;
    logic        [ANGLE_BITS-1:0] turn_angle;

    modport source (output valid, point_x, point_y, center_x, center_y, turn_angle,
                    input ready);
    modport sink (input valid, point_x, point_y, center_x, center_y, turn_angle,
                  output ready);
endinterface

interface prc_result_if
    import prc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] rotated_x;
    logic signed [COORD_BITS-1:0] rotated_y;
    logic                         clipped;

    modport source (output valid, rotated_x, rotated_y, clipped, input ready);
    modport sink (input valid, rotated_x, rotated_y, clipped, output ready);
endinterface

### src/prc_front.sv
`timescale 1ns / 1ps

module prc_front
    import prc_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
    parameter int ROTATION_STAGES = STAGES_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    prc_point_if.sink                    points,
    output logic                         dn_valid,
    input  logic                         dn_ready,
    output logic signed [DATA_W-1:0]     dn_x,
    output logic signed [DATA_W-1:0]     dn_y,
    output logic signed [ZW-1:0]         dn_z,
    output logic signed [COORD_BITS-1:0] dn_cx,
    output logic signed [COORD_BITS-1:0] dn_cy
);

    localparam int          N    = stages_used(ROTATION_STAGES);
    localparam int          G    = FRAC_BASE - COORD_BITS;
    localparam int          DW   = COORD_BITS + 1;
    localparam int          KL   = (G + 1) / 2;
    localparam int          KH   = G - KL;
    localparam logic [63:0] KQ   = gain_q31(N);
    localparam int          UP   = (G >= 31) ? G - 31 : 0;
    localparam int          DN   = (G >= 31) ? 0 : 31 - G;
    localparam logic [63:0] KG   = (KQ << UP) >> DN;
    localparam logic [KL-1:0] KG_LO = KG[KL-1:0];
    localparam logic [KH-1:0] KG_HI = KG[G-1:KL];

    typedef enum logic [1:0] {
        QUAD_0   = 2'd0,
        QUAD_90  = 2'd1,
        QUAD_180 = 2'd2,
        QUAD_270 = 2'd3
    } quad_t;

    logic [FRONT_DEPTH-1:0] v_reg;
    logic [FRONT_DEPTH-1:0] en;

    logic signed [DW-1:0]         dx_reg, dy_reg, dx_next, dy_next;
    logic        [TURN_BITS-1:0]  turn_reg, turn_next;
    logic signed [COORD_BITS-1:0] cx0_reg, cy0_reg;

    logic signed [DW-1:0]         qx_reg, qy_reg, qx_next, qy_next;
    logic signed [ZW-1:0]         z1_reg, z1_next;
    logic signed [COORD_BITS-1:0] cx1_reg, cy1_reg;
    quad_t                        quad;

    logic signed [DW+KL:0]        pxl_reg, pyl_reg;
    logic signed [DW+KH:0]        pxh_reg, pyh_reg;
    logic signed [ZW-1:0]         z2_reg;
    logic signed [COORD_BITS-1:0] cx2_reg, cy2_reg;

    logic signed [DATA_W-1:0]     x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0]         z3_reg;
    logic signed [COORD_BITS-1:0] cx3_reg, cy3_reg;

    assign en[3]        = !v_reg[3] || dn_ready;
    assign en[2]        = !v_reg[2] || en[3];
    assign en[1]        = !v_reg[1] || en[2];
    assign en[0]        = !v_reg[0] || en[1];
    assign points.ready = en[0];
    assign dn_valid     = v_reg[3];

    assign dx_next   = DW'(points.point_x) - DW'(points.center_x);
    assign dy_next   = DW'(points.point_y) - DW'(points.center_y);
    assign turn_next = TURN_BITS'(points.turn_angle) << (TURN_BITS - ANGLE_BITS);

    assign quad    = quad_t'(turn_reg[TURN_BITS-1:TURN_BITS-2]);
    assign z1_next = $signed({{(ZW - RESID_BITS){1'b0}}, turn_reg[RESID_BITS-1:0]});

    always_comb
    begin
        unique case (quad)
            QUAD_90:
            begin
                qx_next = -dy_reg;
                qy_next = dx_reg;
            end
            QUAD_180:
            begin
                qx_next = -dx_reg;
                qy_next = -dy_reg;
            end
            QUAD_270:
            begin
                qx_next = dy_reg;
                qy_next = -dx_reg;
            end
            default:
            begin
                qx_next = dx_reg;
                qy_next = dy_reg;
            end
        endcase
    end

    assign x_next = (DATA_W'(pxh_reg) <<< KL) + DATA_W'(pxl_reg);
    assign y_next = (DATA_W'(pyh_reg) <<< KL) + DATA_W'(pyl_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= points.valid;
            end
            for (int k = 1; k < FRONT_DEPTH; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dx_reg   <= dx_next;
            dy_reg   <= dy_next;
            turn_reg <= turn_next;
            cx0_reg  <= points.center_x;
            cy0_reg  <= points.center_y;
        end
        if (en[1])
        begin
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
            z1_reg  <= z1_next;
            cx1_reg <= cx0_reg;
            cy1_reg <= cy0_reg;
        end
        if (en[2])
        begin
            pxl_reg <= qx_reg * $signed({1'b0, KG_LO});
            pyl_reg <= qy_reg * $signed({1'b0, KG_LO});
            pxh_reg <= qx_reg * $signed({1'b0, KG_HI});
            pyh_reg <= qy_reg * $signed({1'b0, KG_HI});
            z2_reg  <= z1_reg;
            cx2_reg <= cx1_reg;
            cy2_reg <= cy1_reg;
        end
        if (en[3])
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z3_reg  <= z2_reg;
            cx3_reg <= cx2_reg;
            cy3_reg <= cy2_reg;
        end
    end

    assign dn_x  = x_reg;
    assign dn_y  = y_reg;
    assign dn_z  = z3_reg;
    assign dn_cx = cx3_reg;
    assign dn_cy = cy3_reg;

endmodule

### src/prc_micro_stage.sv
`timescale 1ns / 1ps

module prc_micro_stage
    import prc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int SHIFT      = 0
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         up_valid,
    output logic                         up_ready,
    input  logic signed [DATA_W-1:0]     up_x,
    input  logic signed [DATA_W-1:0]     up_y,
    input  logic signed [ZW-1:0]         up_z,
    input  logic signed [COORD_BITS-1:0] up_cx,
    input  logic signed [COORD_BITS-1:0] up_cy,
    output logic                         dn_valid,
    input  logic                         dn_ready,
    output logic signed [DATA_W-1:0]     dn_x,
    output logic signed [DATA_W-1:0]     dn_y,
    output logic signed [ZW-1:0]         dn_z,
    output logic signed [COORD_BITS-1:0] dn_cx,
    output logic signed [COORD_BITS-1:0] dn_cy
);

    localparam logic signed [ZW-1:0] ATAN =
        $signed({{(ZW - TURN_BITS){1'b0}}, ATAN_TURN[SHIFT]});

    logic                         valid_reg;
    logic                         en;
    logic                         ccw;
    logic signed [DATA_W-1:0]     xs, ys;
    logic signed [DATA_W-1:0]     x_reg, y_reg, x_next, y_next;
    logic signed [ZW-1:0]         z_reg, z_next;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;

    assign en       = !valid_reg || dn_ready;
    assign up_ready = en;
    assign dn_valid = valid_reg;

    assign ccw    = !up_z[ZW-1];
    assign xs     = up_x >>> SHIFT;
    assign ys     = up_y >>> SHIFT;
    assign x_next = ccw ? up_x - ys : up_x + ys;
    assign y_next = ccw ? up_y + xs : up_y - xs;
    assign z_next = ccw ? up_z - ATAN : up_z + ATAN;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg  <= x_next;
            y_reg  <= y_next;
            z_reg  <= z_next;
            cx_reg <= up_cx;
            cy_reg <= up_cy;
        end
    end

    assign dn_x  = x_reg;
    assign dn_y  = y_reg;
    assign dn_z  = z_reg;
    assign dn_cx = cx_reg;
    assign dn_cy = cy_reg;

endmodule

### src/prc_back.sv
`timescale 1ns / 1ps

module prc_back
    import prc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         up_valid,
    output logic                         up_ready,
    input  logic signed [DATA_W-1:0]     up_x,
    input  logic signed [DATA_W-1:0]     up_y,
    input  logic signed [COORD_BITS-1:0] up_cx,
    input  logic signed [COORD_BITS-1:0] up_cy,
    prc_result_if.source                 results
);

    localparam int G  = FRAC_BASE - COORD_BITS;
    localparam int SW = DATA_W + 1;
    localparam int RW = SW - G;
    localparam logic signed [SW-1:0] HALF   = SW'(1) <<< (G - 1);
    localparam logic signed [RW-1:0] LIM_HI =
        $signed({{(RW - COORD_BITS + 1){1'b0}}, {(COORD_BITS - 1){1'b1}}});
    localparam logic signed [RW-1:0] LIM_LO = ~LIM_HI;

    logic [BACK_DEPTH-1:0] v_reg;
    logic [BACK_DEPTH-1:0] en;

    logic signed [SW-1:0]         sx, sy;
    logic signed [RW-1:0]         rx_reg, ry_reg, rx_next, ry_next;
    logic signed [COORD_BITS-1:0] ox_reg, oy_reg, ox_next, oy_next;
    logic                         clip_reg, clip_next;
    logic                         hi_x, lo_x, hi_y, lo_y;

    assign en[1]         = !v_reg[1] || results.ready;
    assign en[0]         = !v_reg[0] || en[1];
    assign up_ready      = en[0];
    assign results.valid = v_reg[1];

    // Round half up: add one half below the binary point, then floor.
    assign sx      = SW'(up_x) + (SW'(up_cx) <<< G) + HALF;
    assign sy      = SW'(up_y) + (SW'(up_cy) <<< G) + HALF;
    assign rx_next = RW'(sx >>> G);
    assign ry_next = RW'(sy >>> G);

    assign hi_x = rx_reg > LIM_HI;
    assign lo_x = rx_reg < LIM_LO;
    assign hi_y = ry_reg > LIM_HI;
    assign lo_y = ry_reg < LIM_LO;

    assign ox_next   = hi_x ? COORD_BITS'(LIM_HI) :
                       lo_x ? COORD_BITS'(LIM_LO) : rx_reg[COORD_BITS-1:0];
    assign oy_next   = hi_y ? COORD_BITS'(LIM_HI) :
                       lo_y ? COORD_BITS'(LIM_LO) : ry_reg[COORD_BITS-1:0];
    assign clip_next = hi_x || lo_x || hi_y || lo_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= up_valid;
            end
            if (en[1])
            begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rx_reg <= rx_next;
            ry_reg <= ry_next;
        end
        if (en[1])
        begin
            ox_reg   <= ox_next;
            oy_reg   <= oy_next;
            clip_reg <= clip_next;
        end
    end

    assign results.rotated_x = ox_reg;
    assign results.rotated_y = oy_reg;
    assign results.clipped   = clip_reg;

endmodule

### src/point_rotation_about_center_core.sv
`timescale 1ns / 1ps

// Rotates a point counterclockwise about a centre by a fraction of a full turn, using an
// exact quarter-turn pre-rotation and an unrolled CORDIC with the gain applied up front;
// results are rounded to nearest (ties upward) and saturated, with clipped flagging it.
// One point is taken in every clock unless the pipeline is full and the output is held;
// each passes four stages for the offset, quadrant and gain multiply, one stage per
// micro-rotation (at most MAX_STAGES) and two for rounding and saturation. Every
// stage has its own valid bit and stalls only when the stage after it is full, so
// empty slots are squeezed out while the output is held and no beat is lost or repeated.
module point_rotation_about_center_core
    import prc_pkg::*;
#(
    parameter int COORD_BITS      = COORD_BITS_DEF,
    parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
    parameter int ROTATION_STAGES = STAGES_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    prc_point_if.sink    points,
    prc_result_if.source results
);

    localparam int N     = stages_used(ROTATION_STAGES);
    localparam int DEPTH = FRONT_DEPTH + N + BACK_DEPTH;
    localparam int OCC_W = $clog2(DEPTH + 1);
    localparam logic signed [ZW-1:0] Z_BOUND =
        $signed({{(ZW - TURN_BITS){1'b0}}, ATAN_TURN[N-1]}) * 2 + 64;

    logic                         v_chain [0:N];
    logic                         r_chain [0:N];
    logic signed [DATA_W-1:0]     x_chain [0:N];
    logic signed [DATA_W-1:0]     y_chain [0:N];
    logic signed [ZW-1:0]         z_chain [0:N];
    logic signed [COORD_BITS-1:0] cx_chain [0:N];
    logic signed [COORD_BITS-1:0] cy_chain [0:N];

    prc_front #(
        .COORD_BITS      (COORD_BITS),
        .ANGLE_BITS      (ANGLE_BITS),
        .ROTATION_STAGES (ROTATION_STAGES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .points   (points),
        .dn_valid (v_chain[0]),
        .dn_ready (r_chain[0]),
        .dn_x     (x_chain[0]),
        .dn_y     (y_chain[0]),
        .dn_z     (z_chain[0]),
        .dn_cx    (cx_chain[0]),
        .dn_cy    (cy_chain[0])
    );

    for (genvar i = 0; i < N; i++)
    begin : g_micro
        prc_micro_stage #(
            .COORD_BITS (COORD_BITS),
            .SHIFT      (i)
        ) u_stage (
            .clk      (clk),
            .rst_n    (rst_n),
            .up_valid (v_chain[i]),
            .up_ready (r_chain[i]),
            .up_x     (x_chain[i]),
            .up_y     (y_chain[i]),
            .up_z     (z_chain[i]),
            .up_cx    (cx_chain[i]),
            .up_cy    (cy_chain[i]),
            .dn_valid (v_chain[i+1]),
            .dn_ready (r_chain[i+1]),
            .dn_x     (x_chain[i+1]),
            .dn_y     (y_chain[i+1]),
            .dn_z     (z_chain[i+1]),
            .dn_cx    (cx_chain[i+1]),
            .dn_cy    (cy_chain[i+1])
        );
    end

    prc_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v_chain[N]),
        .up_ready (r_chain[N]),
        .up_x     (x_chain[N]),
        .up_y     (y_chain[N]),
        .up_cx    (cx_chain[N]),
        .up_cy    (cy_chain[N]),
        .results  (results)
    );

    // Number of beats inside the pipeline, kept for the checks below.
    logic [OCC_W-1:0] occ_reg, occ_next;
    logic             take_in, take_out;

    assign take_in  = points.valid && points.ready;
    assign take_out = results.valid && results.ready;
    assign occ_next = occ_reg + OCC_W'(take_in) - OCC_W'(take_out);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    a_ready_matches_room: assert property (@(posedge clk) disable iff (!rst_n)
        points.ready == (results.ready || (occ_reg < OCC_W'(DEPTH))))
        else $error("input ready disagrees with pipeline occupancy");

    a_no_result_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg == '0) |-> !results.valid)
        else $error("result offered with no beat in flight");

    a_angle_converged: assert property (@(posedge clk) disable iff (!rst_n)
        v_chain[N] |-> ((z_chain[N] <= Z_BOUND) && (z_chain[N] >= -Z_BOUND)))
        else $error("residual angle did not converge");

endmodule
